// ===== design/assert_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion wrappers for the frame packer design files.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// property must hold at every clock edge outside reset
`define MCFP_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("assertion failed");
// condition must never be seen outside reset
`define MCFP_NEVER(lbl, clk, rst_n, cond) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error("forbidden condition seen");
`else
`define MCFP_ASSERT(lbl, clk, rst_n, prop)
`define MCFP_NEVER(lbl, clk, rst_n, cond)
`endif
`endif

// ===== design/mcfp_pkg.sv =====
// ----------------------------------------------------------------------------
// mcfp_pkg
// Types and constants of the motor command frame packer.
// ----------------------------------------------------------------------------
package mcfp_pkg;

    localparam int CFG_W     = 32;
    localparam int CFG_IDX_W = 3;
    localparam int VAL_W     = 32;
    localparam int GAIN_W    = 31;

    localparam int POS_CODE_W  = 16;
    localparam int GAIN_CODE_W = 12;

    // quotient bits produced by the divider, one per stage
    localparam int QUO_W     = 16;
    localparam int DIV_STEPS = QUO_W;
    localparam int NUM_W     = VAL_W + QUO_W;

    // clamp low, clamp high, offset, scale, then the divider steps
    localparam int LANE_NS = 4 + DIV_STEPS;
    localparam int PIPE_NS = LANE_NS + 1;

    localparam int FRAME_W = 64;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_POS_MIN    = 3'd0,
        CFG_POS_MAX    = 3'd1,
        CFG_VEL_MIN    = 3'd2,
        CFG_VEL_MAX    = 3'd3,
        CFG_TORQUE_MIN = 3'd4,
        CFG_TORQUE_MAX = 3'd5,
        CFG_KP_MAX     = 3'd6,
        CFG_KD_MAX     = 3'd7
    } t_cfg_idx;

    typedef enum logic [1:0] {
        CMD_CONTROL = 2'd0,
        CMD_ENTER   = 2'd1,
        CMD_EXIT    = 2'd2,
        CMD_ZERO    = 2'd3
    } t_cmd;

    localparam logic [FRAME_W-1:0] FRAME_ENTER = 64'hFFFF_FFFF_FFFF_FFFC;
    localparam logic [FRAME_W-1:0] FRAME_EXIT  = 64'hFFFF_FFFF_FFFF_FFFD;
    localparam logic [FRAME_W-1:0] FRAME_ZERO  = 64'hFFFF_FFFF_FFFF_FFFE;

    localparam logic signed [VAL_W-1:0] RST_POS_MIN    = -32'sd819200;
    localparam logic signed [VAL_W-1:0] RST_POS_MAX    = 32'sd819200;
    localparam logic signed [VAL_W-1:0] RST_VEL_MIN    = -32'sd2949120;
    localparam logic signed [VAL_W-1:0] RST_VEL_MAX    = 32'sd2949120;
    localparam logic signed [VAL_W-1:0] RST_TORQUE_MIN = -32'sd1179648;
    localparam logic signed [VAL_W-1:0] RST_TORQUE_MAX = 32'sd1179648;
    localparam logic [GAIN_W-1:0]       RST_KP_MAX     = 31'd32768000;
    localparam logic [GAIN_W-1:0]       RST_KD_MAX     = 31'd327680;

    typedef struct packed {
        logic [LANE_NS-1:0] ce;
        logic [LANE_NS-1:0] vld;
    } t_lane_ctl;

endpackage

// ===== design/mcfp_lane.sv =====
// ----------------------------------------------------------------------------
// mcfp_lane
// One set-point channel: clamp, offset, scale by the code range and a
// restoring divider that yields one quotient bit per pipeline stage.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module mcfp_lane #(
    parameter int CODE_W = 12
) (
    input  logic                                      i_clk,
    input  logic                                      i_rst_n,
    input  mcfp_pkg::t_lane_ctl                       i_ctl,
    input  logic signed [mcfp_pkg::VAL_W-1:0]         i_x,
    input  logic signed [mcfp_pkg::VAL_W-1:0]         i_lo,
    input  logic signed [mcfp_pkg::VAL_W-1:0]         i_hi,
    output logic        [CODE_W-1:0]                  o_code
);

    localparam int VW   = mcfp_pkg::VAL_W;
    localparam int QW   = mcfp_pkg::QUO_W;
    localparam int NW   = mcfp_pkg::NUM_W;
    localparam int NST  = mcfp_pkg::DIV_STEPS;
    localparam int DIV0 = 3;
    localparam logic [QW-1:0] FULL = QW'((1 << CODE_W) - 1);

    logic        [VW-1:0]       r_span;
    logic                       r_zero;
    logic signed [VW-1:0]       r_x0;
    logic signed [VW-1:0]       r_x1;
    logic        [VW-1:0]       r_diff;
    logic        [NW-1:0]       n_num;
    logic        [VW-1:0]       r_rem [0:NST];
    logic        [QW-1:0]       r_low [0:NST];
    logic        [QW-1:0]       r_quo [0:NST];

    // the user must change limits only while idle; this block does not enforce it
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_zero <= 1'b1;
            r_span <= '0;
        end else begin
            r_zero <= !(i_hi > i_lo);
            r_span <= VW'(i_hi - i_lo);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.ce[0]) begin
            r_x0 <= (i_x < i_lo) ? i_lo : i_x;
        end
        if (i_ctl.ce[1]) begin
            r_x1 <= (r_x0 > i_hi) ? i_hi : r_x0;
        end
        if (i_ctl.ce[2]) begin
            r_diff <= VW'(r_x1 - i_lo);
        end
    end

    // diff * (2^CODE_W - 1)
    assign n_num = (NW'(r_diff) << CODE_W) - NW'(r_diff);

    always_ff @(posedge i_clk) begin
        if (i_ctl.ce[DIV0]) begin
            r_rem[0] <= n_num[NW-1:QW];
            r_low[0] <= n_num[QW-1:0];
            r_quo[0] <= '0;
        end
    end

    for (genvar k = 1; k <= NST; k++) begin : g_div
        logic [VW:0]   w_trial;
        logic [VW+1:0] w_sub;
        logic          w_ge;

        assign w_trial = {r_rem[k-1], r_low[k-1][QW-1]};
        assign w_sub   = {1'b0, w_trial} - {2'b00, r_span};
        assign w_ge    = !w_sub[VW+1];

        always_ff @(posedge i_clk) begin
            if (i_ctl.ce[DIV0+k]) begin
                r_rem[k] <= w_ge ? w_sub[VW-1:0] : w_trial[VW-1:0];
                r_low[k] <= {r_low[k-1][QW-2:0], 1'b0};
                r_quo[k] <= {r_quo[k-1][QW-2:0], w_ge};
            end
        end
    end

    assign o_code = r_zero ? '0 : r_quo[NST][CODE_W-1:0];

    `MCFP_ASSERT(a_offset_in_span, i_clk, i_rst_n,
        (i_ctl.vld[2] && !r_zero) |-> (r_diff <= r_span))
    `MCFP_ASSERT(a_rem_below_span, i_clk, i_rst_n,
        (i_ctl.vld[DIV0+8] && !r_zero) |-> (r_rem[8] < r_span))
    `MCFP_ASSERT(a_code_in_range, i_clk, i_rst_n,
        (i_ctl.vld[DIV0+NST] && !r_zero) |-> (r_quo[NST] <= FULL))

endmodule

// ===== design/motor_command_frame_packer_core.sv =====
// ----------------------------------------------------------------------------
// motor_command_frame_packer_core
// Builds the 8-byte payload of a motor command frame from one command item.
// ----------------------------------------------------------------------------
// Input items arrive on s_axis: tuser carries the command kind, tdata the five
// Q16.16 set-points. Each item yields exactly one 64-bit payload on m_axis,
// first frame byte in tdata[63:56]. Limits are written through the i_cfg_*
// port; the user must write them only while no item is in flight, which the
// block does not enforce. Register i of the limit list is index i. Control
// items are clamped, offset and scaled, then divided by the limit span in a
// restoring divider that resolves one quotient bit per stage. While m_axis is
// not stalled, one item is taken and one produced per cycle. Every stage has
// its own valid bit; a stage advances when it is empty or the one after it
// advances, so bubbles collapse under a stall. s_axis_tready drops only when
// all stages hold items and m_axis is stalled; nothing is dropped or repeated.
// Reset empties the pipeline and loads the default limits.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module motor_command_frame_packer_core (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_cfg_wr_en,
    input  logic [mcfp_pkg::CFG_IDX_W-1:0]     i_cfg_addr,
    input  logic [mcfp_pkg::CFG_W-1:0]         i_cfg_wdata,
    input  logic                               s_axis_tvalid,
    output logic                               s_axis_tready,
    // [31:0] target_position, [63:32] target_velocity, [95:64] stiffness,
    // [127:96] damping, [159:128] feed_torque
    input  logic [159:0]                       s_axis_tdata,
    // [1:0] cmd
    input  logic [1:0]                         s_axis_tuser,
    output logic                               m_axis_tvalid,
    input  logic                               m_axis_tready,
    // [63:0] frame_payload
    output logic [mcfp_pkg::FRAME_W-1:0]       m_axis_tdata
);

    localparam int VW  = mcfp_pkg::VAL_W;
    localparam int GW  = mcfp_pkg::GAIN_W;
    localparam int LNS = mcfp_pkg::LANE_NS;
    localparam int PNS = mcfp_pkg::PIPE_NS;
    localparam int PCW = mcfp_pkg::POS_CODE_W;
    localparam int GCW = mcfp_pkg::GAIN_CODE_W;

    logic signed [VW-1:0] r_pos_min;
    logic signed [VW-1:0] r_pos_max;
    logic signed [VW-1:0] r_vel_min;
    logic signed [VW-1:0] r_vel_max;
    logic signed [VW-1:0] r_torque_min;
    logic signed [VW-1:0] r_torque_max;
    logic [GW-1:0]        r_kp_max;
    logic [GW-1:0]        r_kd_max;

    logic [PNS-1:0]       r_vld;
    logic [PNS-1:0]       w_ce;
    mcfp_pkg::t_cmd       r_cmd [0:LNS-1];
    mcfp_pkg::t_lane_ctl  w_ctl;
    logic [mcfp_pkg::FRAME_W-1:0] r_frame;
    logic [mcfp_pkg::FRAME_W-1:0] n_frame;

    logic [PCW-1:0]       w_pos_code;
    logic [GCW-1:0]       w_vel_code;
    logic [GCW-1:0]       w_kp_code;
    logic [GCW-1:0]       w_kd_code;
    logic [GCW-1:0]       w_tq_code;

    // limit registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos_min    <= mcfp_pkg::RST_POS_MIN;
            r_pos_max    <= mcfp_pkg::RST_POS_MAX;
            r_vel_min    <= mcfp_pkg::RST_VEL_MIN;
            r_vel_max    <= mcfp_pkg::RST_VEL_MAX;
            r_torque_min <= mcfp_pkg::RST_TORQUE_MIN;
            r_torque_max <= mcfp_pkg::RST_TORQUE_MAX;
            r_kp_max     <= mcfp_pkg::RST_KP_MAX;
            r_kd_max     <= mcfp_pkg::RST_KD_MAX;
        end else if (i_cfg_wr_en) begin
            unique case (mcfp_pkg::t_cfg_idx'(i_cfg_addr))
                mcfp_pkg::CFG_POS_MIN:    r_pos_min    <= i_cfg_wdata;
                mcfp_pkg::CFG_POS_MAX:    r_pos_max    <= i_cfg_wdata;
                mcfp_pkg::CFG_VEL_MIN:    r_vel_min    <= i_cfg_wdata;
                mcfp_pkg::CFG_VEL_MAX:    r_vel_max    <= i_cfg_wdata;
                mcfp_pkg::CFG_TORQUE_MIN: r_torque_min <= i_cfg_wdata;
                mcfp_pkg::CFG_TORQUE_MAX: r_torque_max <= i_cfg_wdata;
                mcfp_pkg::CFG_KP_MAX:     r_kp_max     <= i_cfg_wdata[GW-1:0];
                mcfp_pkg::CFG_KD_MAX:     r_kd_max     <= i_cfg_wdata[GW-1:0];
                default: ;
            endcase
        end
    end

    // stage advance chain, back to front
    always_comb begin
        w_ce[PNS-1] = !r_vld[PNS-1] || m_axis_tready;
        for (int k = PNS - 2; k >= 0; k--) begin
            w_ce[k] = !r_vld[k] || w_ce[k+1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            if (w_ce[0]) begin
                r_vld[0] <= s_axis_tvalid;
            end
            for (int k = 1; k < PNS; k++) begin
                if (w_ce[k]) begin
                    r_vld[k] <= r_vld[k-1];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_ce[0]) begin
            r_cmd[0] <= mcfp_pkg::t_cmd'(s_axis_tuser);
        end
        for (int k = 1; k < LNS; k++) begin
            if (w_ce[k]) begin
                r_cmd[k] <= r_cmd[k-1];
            end
        end
    end

    assign w_ctl.ce  = w_ce[LNS-1:0];
    assign w_ctl.vld = r_vld[LNS-1:0];

    mcfp_lane #(.CODE_W(PCW)) u_pos (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (w_ctl),
        .i_x     (s_axis_tdata[31:0]),
        .i_lo    (r_pos_min),
        .i_hi    (r_pos_max),
        .o_code  (w_pos_code)
    );

    mcfp_lane #(.CODE_W(GCW)) u_vel (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (w_ctl),
        .i_x     (s_axis_tdata[63:32]),
        .i_lo    (r_vel_min),
        .i_hi    (r_vel_max),
        .o_code  (w_vel_code)
    );

    mcfp_lane #(.CODE_W(GCW)) u_kp (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (w_ctl),
        .i_x     (s_axis_tdata[95:64]),
        .i_lo    ('0),
        .i_hi    ({1'b0, r_kp_max}),
        .o_code  (w_kp_code)
    );

    mcfp_lane #(.CODE_W(GCW)) u_kd (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (w_ctl),
        .i_x     (s_axis_tdata[127:96]),
        .i_lo    ('0),
        .i_hi    ({1'b0, r_kd_max}),
        .o_code  (w_kd_code)
    );

    mcfp_lane #(.CODE_W(GCW)) u_tq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (w_ctl),
        .i_x     (s_axis_tdata[159:128]),
        .i_lo    (r_torque_min),
        .i_hi    (r_torque_max),
        .o_code  (w_tq_code)
    );

    always_comb begin
        unique case (r_cmd[LNS-1])
            mcfp_pkg::CMD_CONTROL: n_frame = {w_pos_code, w_vel_code, w_kp_code,
                                              w_kd_code, w_tq_code};
            mcfp_pkg::CMD_ENTER:   n_frame = mcfp_pkg::FRAME_ENTER;
            mcfp_pkg::CMD_EXIT:    n_frame = mcfp_pkg::FRAME_EXIT;
            mcfp_pkg::CMD_ZERO:    n_frame = mcfp_pkg::FRAME_ZERO;
            default:               n_frame = mcfp_pkg::FRAME_ZERO;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (w_ce[PNS-1]) begin
            r_frame <= n_frame;
        end
    end

    assign s_axis_tready = w_ce[0];
    assign m_axis_tvalid = r_vld[PNS-1];
    assign m_axis_tdata  = r_frame;

    `MCFP_ASSERT(a_stall_only_when_full, i_clk, i_rst_n,
        !s_axis_tready |-> (&r_vld))
    `MCFP_ASSERT(a_accept_fills_entry, i_clk, i_rst_n,
        (s_axis_tvalid && s_axis_tready) |=> r_vld[0])
    `MCFP_ASSERT(a_held_entry_kept, i_clk, i_rst_n,
        (r_vld[0] && !w_ce[0]) |=> r_vld[0])

endmodule

// ===== test/tb_motor_command_frame_packer_core.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_motor_command_frame_packer_core
// Self-checking bench for the command frame packer: drives command items
// under several limit sets and pacing modes, predicts every payload from
// the limits last written and compares each output item in arrival order.
// ----------------------------------------------------------------------------
module tb_motor_command_frame_packer_core;

    class frame_scoreboard;
        longint pos_lo, pos_hi, vel_lo, vel_hi, trq_lo, trq_hi, kp_hi, kd_hi;
        logic [mcfp_pkg::FRAME_W-1:0] frames_due[$];
        int errors;

        function void load_defaults();
            pos_lo = mcfp_pkg::RST_POS_MIN;
            pos_hi = mcfp_pkg::RST_POS_MAX;
            vel_lo = mcfp_pkg::RST_VEL_MIN;
            vel_hi = mcfp_pkg::RST_VEL_MAX;
            trq_lo = mcfp_pkg::RST_TORQUE_MIN;
            trq_hi = mcfp_pkg::RST_TORQUE_MAX;
            kp_hi  = mcfp_pkg::RST_KP_MAX;
            kd_hi  = mcfp_pkg::RST_KD_MAX;
        endfunction

        function void set_limit(mcfp_pkg::t_cfg_idx idx, logic [mcfp_pkg::CFG_W-1:0] v);
            case (idx)
                mcfp_pkg::CFG_POS_MIN:    pos_lo = longint'($signed(v));
                mcfp_pkg::CFG_POS_MAX:    pos_hi = longint'($signed(v));
                mcfp_pkg::CFG_VEL_MIN:    vel_lo = longint'($signed(v));
                mcfp_pkg::CFG_VEL_MAX:    vel_hi = longint'($signed(v));
                mcfp_pkg::CFG_TORQUE_MIN: trq_lo = longint'($signed(v));
                mcfp_pkg::CFG_TORQUE_MAX: trq_hi = longint'($signed(v));
                mcfp_pkg::CFG_KP_MAX:     kp_hi  = longint'(v[mcfp_pkg::GAIN_W-1:0]);
                mcfp_pkg::CFG_KD_MAX:     kd_hi  = longint'(v[mcfp_pkg::GAIN_W-1:0]);
                default: ;
            endcase
        endfunction

        // clamp, then floor((x - lo) * (2^bits - 1) / (hi - lo)); empty span gives 0
        function longint unsigned level_code(longint x, longint lo, longint hi, int bits);
            longint unsigned full, diff, span;
            full = (64'd1 << bits) - 1;
            if (x < lo) x = lo;
            if (x > hi) x = hi;
            if (hi <= lo) return 0;
            diff = x - lo;
            span = hi - lo;
            return ((diff * full) / span) & full;
        endfunction

        function void note_command(mcfp_pkg::t_cmd cmd, logic [159:0] d);
            logic [mcfp_pkg::FRAME_W-1:0] f;
            longint unsigned p, v, kp, kd, t;
            case (cmd)
                mcfp_pkg::CMD_ENTER: f = mcfp_pkg::FRAME_ENTER;
                mcfp_pkg::CMD_EXIT:  f = mcfp_pkg::FRAME_EXIT;
                mcfp_pkg::CMD_ZERO:  f = mcfp_pkg::FRAME_ZERO;
                default: begin
                    p  = level_code($signed(d[31:0]), pos_lo, pos_hi,
                                    mcfp_pkg::POS_CODE_W);
                    v  = level_code($signed(d[63:32]), vel_lo, vel_hi,
                                    mcfp_pkg::GAIN_CODE_W);
                    kp = level_code($signed(d[95:64]), 0, kp_hi, mcfp_pkg::GAIN_CODE_W);
                    kd = level_code($signed(d[127:96]), 0, kd_hi, mcfp_pkg::GAIN_CODE_W);
                    t  = level_code($signed(d[159:128]), trq_lo, trq_hi,
                                    mcfp_pkg::GAIN_CODE_W);
                    f  = {p[15:0], v[11:0], kp[11:0], kd[11:0], t[11:0]};
                end
            endcase
            frames_due.push_back(f);
        endfunction

        function void check_frame(logic [mcfp_pkg::FRAME_W-1:0] got);
            logic [mcfp_pkg::FRAME_W-1:0] want;
            if (frames_due.size() == 0) begin
                $display("%0t: payload with none pending, expected none actual %h",
                         $time, got);
                errors++;
                return;
            end
            want = frames_due.pop_front();
            if (got !== want) begin
                $display("%0t: frame_payload mismatch expected %h actual %h",
                         $time, want, got);
                errors++;
            end
        endfunction

        function int pending();
            return frames_due.size();
        endfunction
    endclass

    logic                           i_clk = 1'b0;
    logic                           i_rst_n = 1'b0;
    logic                           i_cfg_wr_en = 1'b0;
    logic [mcfp_pkg::CFG_IDX_W-1:0] i_cfg_addr = '0;
    logic [mcfp_pkg::CFG_W-1:0]     i_cfg_wdata = '0;
    logic                           s_axis_tvalid = 1'b0;
    logic                           s_axis_tready;
    // [31:0] target_position, [63:32] target_velocity, [95:64] stiffness,
    // [127:96] damping, [159:128] feed_torque
    logic [159:0]                   s_axis_tdata = '0;
    // [1:0] cmd
    logic [1:0]                     s_axis_tuser = '0;
    logic                           m_axis_tvalid;
    logic                           m_axis_tready = 1'b0;
    // [63:0] frame_payload
    logic [mcfp_pkg::FRAME_W-1:0]   m_axis_tdata;

    frame_scoreboard sb;
    int send_idle_pct = 0;
    int recv_stall_pct = 0;
    logic [mcfp_pkg::CFG_W-1:0] limit_val [0:7];

    motor_command_frame_packer_core DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_addr    (i_cfg_addr),
        .i_cfg_wdata   (i_cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always #5 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        if (i_rst_n && s_axis_tvalid && s_axis_tready)
            sb.note_command(mcfp_pkg::t_cmd'(s_axis_tuser), s_axis_tdata);
        if (i_rst_n && m_axis_tvalid && m_axis_tready)
            sb.check_frame(m_axis_tdata);
        m_axis_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
    end

    initial begin
        #5ms;
        $display("FAILURE");
        $finish;
    end

    function automatic logic [159:0] pack5(logic [31:0] p, logic [31:0] v,
                                           logic [31:0] kp, logic [31:0] kd,
                                           logic [31:0] t);
        return {t, kd, kp, v, p};
    endfunction

    // set-point aimed at a limit range: edges, just outside, inside, or anything
    function automatic logic [31:0] near_range(longint lo, longint hi);
        longint unsigned span;
        case ($urandom_range(0, 9))
            0, 1: return $urandom;
            2:    return lo[31:0];
            3:    return hi[31:0];
            4:    return lo[31:0] - 32'd1;
            5:    return hi[31:0] + 32'd1;
            default: begin
                if (hi <= lo) return $urandom;
                span = hi - lo + 1;
                return lo[31:0] + 32'({$urandom, $urandom} % span);
            end
        endcase
    endfunction

    task automatic send_item(input mcfp_pkg::t_cmd cmd, input logic [159:0] d);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= cmd;
        s_axis_tdata  <= d;
        do @(posedge i_clk); while (!(s_axis_tvalid && s_axis_tready));
    endtask

    task automatic random_item();
        logic [159:0] d;
        if ($urandom_range(0, 9) < 7) begin
            d = pack5(near_range(sb.pos_lo, sb.pos_hi), near_range(sb.vel_lo, sb.vel_hi),
                      near_range(0, sb.kp_hi), near_range(0, sb.kd_hi),
                      near_range(sb.trq_lo, sb.trq_hi));
            send_item(mcfp_pkg::CMD_CONTROL, d);
        end else begin
            d = {$urandom, $urandom, $urandom, $urandom, $urandom};
            send_item(mcfp_pkg::t_cmd'($urandom_range(mcfp_pkg::CMD_ENTER,
                                                      mcfp_pkg::CMD_ZERO)), d);
        end
    endtask

    // stop sending, wait out every pending payload and the pipeline depth
    task automatic drain();
        s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (mcfp_pkg::PIPE_NS + 4) @(posedge i_clk);
    endtask

    task automatic rand_pair(output logic [31:0] lo, output logic [31:0] hi);
        lo = $urandom;
        case ($urandom_range(0, 3))
            0: hi = $urandom;
            1: hi = lo + $urandom_range(1, 300);
            default: begin
                hi = $urandom;
                if ($signed(lo) > $signed(hi)) {lo, hi} = {hi, lo};
            end
        endcase
    endtask

    task automatic pick_limits(input int ph);
        logic [31:0] a;
        case (ph)
            1: begin
                limit_val[mcfp_pkg::CFG_POS_MIN]    = 32'h8000_0000;
                limit_val[mcfp_pkg::CFG_POS_MAX]    = 32'h7FFF_FFFF;
                limit_val[mcfp_pkg::CFG_VEL_MIN]    = 32'h8000_0000;
                limit_val[mcfp_pkg::CFG_VEL_MAX]    = 32'h7FFF_FFFF;
                limit_val[mcfp_pkg::CFG_TORQUE_MIN] = 32'h8000_0000;
                limit_val[mcfp_pkg::CFG_TORQUE_MAX] = 32'h7FFF_FFFF;
                limit_val[mcfp_pkg::CFG_KP_MAX]     = 32'h7FFF_FFFF;
                limit_val[mcfp_pkg::CFG_KD_MAX]     = 32'hFFFF_FFFF;
            end
            2: begin
                // max below min
                limit_val[mcfp_pkg::CFG_POS_MIN]    = mcfp_pkg::RST_POS_MAX;
                limit_val[mcfp_pkg::CFG_POS_MAX]    = mcfp_pkg::RST_POS_MIN;
                limit_val[mcfp_pkg::CFG_VEL_MIN]    = mcfp_pkg::RST_VEL_MAX;
                limit_val[mcfp_pkg::CFG_VEL_MAX]    = mcfp_pkg::RST_VEL_MIN;
                limit_val[mcfp_pkg::CFG_TORQUE_MIN] = mcfp_pkg::RST_TORQUE_MAX;
                limit_val[mcfp_pkg::CFG_TORQUE_MAX] = mcfp_pkg::RST_TORQUE_MIN;
                limit_val[mcfp_pkg::CFG_KP_MAX]     = 32'h0;
                limit_val[mcfp_pkg::CFG_KD_MAX]     = 32'h8000_0000;
            end
            3: begin
                // max equal to min
                a = $urandom;
                limit_val[mcfp_pkg::CFG_POS_MIN]    = a;
                limit_val[mcfp_pkg::CFG_POS_MAX]    = a;
                a = $urandom;
                limit_val[mcfp_pkg::CFG_VEL_MIN]    = a;
                limit_val[mcfp_pkg::CFG_VEL_MAX]    = a;
                a = $urandom;
                limit_val[mcfp_pkg::CFG_TORQUE_MIN] = a;
                limit_val[mcfp_pkg::CFG_TORQUE_MAX] = a;
                limit_val[mcfp_pkg::CFG_KP_MAX]     = 32'h1;
                limit_val[mcfp_pkg::CFG_KD_MAX]     = $urandom_range(1, 64);
            end
            default: begin
                rand_pair(limit_val[mcfp_pkg::CFG_POS_MIN],
                          limit_val[mcfp_pkg::CFG_POS_MAX]);
                rand_pair(limit_val[mcfp_pkg::CFG_VEL_MIN],
                          limit_val[mcfp_pkg::CFG_VEL_MAX]);
                rand_pair(limit_val[mcfp_pkg::CFG_TORQUE_MIN],
                          limit_val[mcfp_pkg::CFG_TORQUE_MAX]);
                limit_val[mcfp_pkg::CFG_KP_MAX] = $urandom;
                limit_val[mcfp_pkg::CFG_KD_MAX] = ($urandom_range(0, 1) == 0)
                                                  ? $urandom : $urandom_range(1, 500);
            end
        endcase
    endtask

    task automatic write_limits();
        for (int i = 0; i < 8; i++) begin
            i_cfg_wr_en <= 1'b1;
            i_cfg_addr  <= mcfp_pkg::t_cfg_idx'(i);
            i_cfg_wdata <= limit_val[i];
            @(posedge i_clk);
            sb.set_limit(mcfp_pkg::t_cfg_idx'(i), limit_val[i]);
        end
        i_cfg_wr_en <= 1'b0;
    endtask

    initial begin
        sb = new();
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        sb.load_defaults();
        @(posedge i_clk);

        for (int ph = 0; ph < 8; ph++) begin
            if (ph > 0) begin
                drain();
                pick_limits(ph);
                write_limits();
            end
            case (ph % 4)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 70; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 70; end
                default: begin send_idle_pct = 38; recv_stall_pct = 38; end
            endcase
            if (ph == 0) begin
                send_item(mcfp_pkg::CMD_ENTER, '0);
                send_item(mcfp_pkg::CMD_EXIT, '1);
                send_item(mcfp_pkg::CMD_ZERO,
                          {$urandom, $urandom, $urandom, $urandom, $urandom});
                send_item(mcfp_pkg::CMD_CONTROL, '0);
                send_item(mcfp_pkg::CMD_CONTROL, '1);
                send_item(mcfp_pkg::CMD_CONTROL, {5{32'h8000_0000}});
                send_item(mcfp_pkg::CMD_CONTROL, {5{32'h7FFF_FFFF}});
                send_item(mcfp_pkg::CMD_CONTROL,
                          pack5(mcfp_pkg::RST_POS_MIN, mcfp_pkg::RST_VEL_MIN, 32'd0, 32'd0,
                                mcfp_pkg::RST_TORQUE_MIN));
                send_item(mcfp_pkg::CMD_CONTROL,
                          pack5(mcfp_pkg::RST_POS_MAX, mcfp_pkg::RST_VEL_MAX,
                                mcfp_pkg::RST_KP_MAX, mcfp_pkg::RST_KD_MAX,
                                mcfp_pkg::RST_TORQUE_MAX));
                send_item(mcfp_pkg::CMD_CONTROL,
                          pack5(mcfp_pkg::RST_POS_MIN - 1, mcfp_pkg::RST_VEL_MIN - 1,
                                32'hFFFF_FFFF, 32'hFFFF_FFFF,
                                mcfp_pkg::RST_TORQUE_MIN - 1));
                send_item(mcfp_pkg::CMD_CONTROL,
                          pack5(mcfp_pkg::RST_POS_MAX + 1, mcfp_pkg::RST_VEL_MAX + 1,
                                mcfp_pkg::RST_KP_MAX + 1, mcfp_pkg::RST_KD_MAX + 1,
                                mcfp_pkg::RST_TORQUE_MAX + 1));
                send_item(mcfp_pkg::CMD_CONTROL,
                          pack5(mcfp_pkg::RST_POS_MIN + 1, mcfp_pkg::RST_VEL_MAX - 1,
                                mcfp_pkg::RST_KP_MAX - 1, 32'd1,
                                mcfp_pkg::RST_TORQUE_MAX - 1));
                send_item(mcfp_pkg::CMD_CONTROL,
                          pack5(32'd0, 32'd0, mcfp_pkg::RST_KP_MAX / 2,
                                mcfp_pkg::RST_KD_MAX / 2, 32'd0));
            end
            for (int n = 0; n < 250; n++) random_item();
        end

        drain();
        if (sb.errors == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
